// File: src/utf8_scan_decode_match_trim_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the UTF-8 scan/decode/match block
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_SCAN_DECODE_MATCH_TRIM_DEFINES_SVH
`define UTF8_SCAN_DECODE_MATCH_TRIM_DEFINES_SVH

// same-cycle implication
`define USDMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define USDMT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/usdmt_pkg.sv
// ---------------------------------------------------------------------------
// usdmt_pkg
// Types and constants shared by the UTF-8 scan/decode/match block.
// ---------------------------------------------------------------------------
package usdmt_pkg;

  localparam int SET_SIZE       = 4;   // match characters compared
  localparam int NUM_MATCH_REGS = 4;   // match registers in the map
  localparam int QDEPTH         = 4;   // front-to-back queue depth
  localparam int QAW            = $clog2(QDEPTH);

  // UTF-8 byte classes
  localparam logic [7:0] ASCII_MASK  = 8'h80;
  localparam logic [7:0] LEAD3_MASK  = 8'hf0;
  localparam logic [7:0] LEAD3_PFX   = 8'he0;
  localparam logic [7:0] LEAD2_MASK  = 8'he0;
  localparam logic [7:0] LEAD2_PFX   = 8'hc0;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_PFX    = 8'h80;

  localparam logic RESULT_CHAR    = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    REG_SET_COUNT = 3'd0,
    REG_MATCH_0   = 3'd1,
    REG_MATCH_1   = 3'd2,
    REG_MATCH_2   = 3'd3,
    REG_MATCH_3   = 3'd4,
    REG_MAX_LEN   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] code_point;
    logic [15:0] char_offset;
    logic [1:0]  char_len;
    logic        is_match;
    logic        found;
    logic [15:0] match_offset;
    logic [15:0] trim_end;
    logic [15:0] valid_bytes;
    logic        decode_error;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [2:0]                            set_count;
    logic [NUM_MATCH_REGS-1:0][15:0]       match_char;
    logic [15:0]                           max_len;
  } cfg_t;

  // work handed from the decoder to the matcher
  typedef struct packed {
    logic        has_char;   // a character completed on this byte
    logic        last;       // end of string, summary due
    logic [15:0] cp;
    logic [15:0] start;
    logic [1:0]  len;
    logic [15:0] pos;        // char_start after this byte
    logic        err;        // final error flag (summary only)
  } entry_t;

endpackage

// File: src/usdmt_front.sv
// ---------------------------------------------------------------------------
// usdmt_front
// Byte decoder: tracks UTF-8 sequences, offsets and stop/error state.
// ---------------------------------------------------------------------------
module usdmt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  usdmt_pkg::in_t    in_data,
  output logic              in_stall,
  input  logic [15:0]       max_len,
  input  logic              q_full,
  output logic              q_push,
  output usdmt_pkg::entry_t q_entry
);

  logic [1:0]  pending, pending_next;
  logic [9:0]  partial, partial_next;
  logic [1:0]  seq_len, seq_len_next;
  logic [15:0] char_start, char_start_next;
  logic        stopped, stopped_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic        emit;
  logic [15:0] cp;
  logic [1:0]  c_len;
  logic [1:0]  len_now;
  logic [16:0] end_sum;
  logic [15:0] end_sat;
  logic [7:0]  b;

  assign b        = in_data.data_byte;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign len_now = (pending == 2'd0) ? 2'd1 : seq_len;
  assign end_sum = {1'b0, char_start} + {15'd0, len_now};
  assign end_sat = end_sum[16] ? 16'hffff : end_sum[15:0];

  always_comb begin
    pending_next    = pending;
    partial_next    = partial;
    seq_len_next    = seq_len;
    char_start_next = char_start;
    stopped_next    = stopped;
    error_seen_next = error_seen;
    emit            = 1'b0;
    cp              = 16'd0;
    c_len           = seq_len;
    if (!stopped) begin
      if (pending == 2'd0) begin
        if (char_start >= max_len) begin
          stopped_next = 1'b1;
        end else if (b == 8'h00) begin
          stopped_next = 1'b1;
        end else if ((b & usdmt_pkg::ASCII_MASK) == 8'h00) begin
          emit            = 1'b1;
          cp              = {8'h00, b};
          c_len           = 2'd1;
          char_start_next = end_sat;
          seq_len_next    = 2'd0;
          partial_next    = 10'd0;
        end else if ((b & usdmt_pkg::LEAD3_MASK) == usdmt_pkg::LEAD3_PFX) begin
          seq_len_next = 2'd3;
          pending_next = 2'd2;
          partial_next = {6'd0, b[3:0]};
        end else if ((b & usdmt_pkg::LEAD2_MASK) == usdmt_pkg::LEAD2_PFX) begin
          seq_len_next = 2'd2;
          pending_next = 2'd1;
          partial_next = {5'd0, b[4:0]};
        end else begin
          stopped_next    = 1'b1;
          error_seen_next = 1'b1;
        end
      end else if ((b & usdmt_pkg::CONT_MASK) != usdmt_pkg::CONT_PFX) begin
        stopped_next    = 1'b1;
        pending_next    = 2'd0;
        error_seen_next = 1'b1;
      end else begin
        pending_next = pending - 2'd1;
        if (pending_next != 2'd0) begin
          partial_next = {partial[3:0], b[5:0]};
        end else begin
          emit            = 1'b1;
          cp              = {partial, b[5:0]};
          c_len           = seq_len;
          char_start_next = end_sat;
          seq_len_next    = 2'd0;
          partial_next    = 10'd0;
        end
      end
    end
  end

  always_comb begin
    q_entry.has_char = emit;
    q_entry.last     = in_data.last_byte;
    q_entry.cp       = cp;
    q_entry.start    = char_start;
    q_entry.len      = c_len;
    q_entry.pos      = char_start_next;
    // a sequence still open at the last byte is an error
    q_entry.err      = error_seen_next || (!stopped_next && (pending_next != 2'd0));
  end

  assign q_push = accept && (emit || in_data.last_byte);

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_byte)) begin
      pending    <= 2'd0;
      partial    <= 10'd0;
      seq_len    <= 2'd0;
      char_start <= 16'd0;
      stopped    <= 1'b0;
      error_seen <= 1'b0;
    end else if (accept) begin
      pending    <= pending_next;
      partial    <= partial_next;
      seq_len    <= seq_len_next;
      char_start <= char_start_next;
      stopped    <= stopped_next;
      error_seen <= error_seen_next;
    end
  end

endmodule

// File: src/usdmt_queue.sv
// ---------------------------------------------------------------------------
// usdmt_queue
// Short FIFO of decoder work between the front and back halves.
// ---------------------------------------------------------------------------
`include "utf8_scan_decode_match_trim_defines.svh"

module usdmt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  usdmt_pkg::entry_t push_entry,
  input  logic              pop,
  output usdmt_pkg::entry_t head,
  output logic              q_valid,
  output logic              q_full
);

  localparam logic [usdmt_pkg::QAW:0] CNT_FULL = (usdmt_pkg::QAW+1)'(usdmt_pkg::QDEPTH);

  usdmt_pkg::entry_t          slots [usdmt_pkg::QDEPTH];
  logic [usdmt_pkg::QAW-1:0]  wr_ptr;
  logic [usdmt_pkg::QAW-1:0]  rd_ptr;
  logic [usdmt_pkg::QAW:0]    count;

  assign head    = slots[rd_ptr];
  assign q_valid = (count != '0);
  assign q_full  = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `USDMT_ASSERT_IMP(a_q_count_range, 1'b1, count <= CNT_FULL, "queue count out of range")
  `USDMT_ASSERT_IMP(a_q_no_overflow, push, !q_full, "push into full queue")
  `USDMT_ASSERT_IMP(a_q_no_underflow, pop, q_valid, "pop from empty queue")

endmodule

// File: src/usdmt_back.sv
// ---------------------------------------------------------------------------
// usdmt_back
// Matcher and result builder: set compare, first-match/trim tracking, output.
// ---------------------------------------------------------------------------
`include "utf8_scan_decode_match_trim_defines.svh"

module usdmt_back (
  input  logic              clk,
  input  logic              rst,
  input  usdmt_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  usdmt_pkg::entry_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output usdmt_pkg::out_t   out_data
);

  logic        match_seen, match_seen_next;
  logic [15:0] first_match_at, first_match_at_next;
  logic [15:0] keep_end, keep_end_next;
  logic        phase, phase_next;   // char of a last entry sent, summary next

  logic                       load;
  logic                       do_char;
  logic                       issue_sum;
  logic [2:0]                 n_act;
  logic [usdmt_pkg::SET_SIZE-1:0] hit_vec;
  logic                       hit;
  logic [15:0]                trim;
  usdmt_pkg::out_t            res;

  assign load      = q_valid && (!out_valid || !out_stall);
  assign do_char   = head.has_char && !phase;
  assign issue_sum = load && !do_char;
  assign pop       = load && !(do_char && head.last);

  assign n_act = (cfg.set_count > 3'(usdmt_pkg::SET_SIZE)) ?
                 3'(usdmt_pkg::SET_SIZE) : cfg.set_count;

  always_comb begin
    for (int j = 0; j < usdmt_pkg::SET_SIZE; j++) begin
      hit_vec[j] = (3'(j) < n_act) && (cfg.match_char[j] == head.cp);
    end
  end
  assign hit = |hit_vec;

  assign trim = (keep_end < cfg.max_len) ? keep_end : cfg.max_len;

  always_comb begin
    res                 = '0;
    match_seen_next     = match_seen;
    first_match_at_next = first_match_at;
    keep_end_next       = keep_end;
    phase_next          = phase;
    if (do_char) begin
      res.result_kind = usdmt_pkg::RESULT_CHAR;
      res.code_point  = head.cp;
      res.char_offset = head.start;
      res.char_len    = head.len;
      res.is_match    = hit;
      if (hit) begin
        if (!match_seen) begin
          match_seen_next     = 1'b1;
          first_match_at_next = head.start;
        end
      end else begin
        keep_end_next = head.pos;
      end
      phase_next = head.last;
    end else begin
      res.result_kind  = usdmt_pkg::RESULT_SUMMARY;
      res.found        = match_seen;
      res.match_offset = first_match_at;
      res.trim_end     = trim;
      res.valid_bytes  = head.pos;
      res.decode_error = head.err;
      res.last_result  = 1'b1;
      match_seen_next     = 1'b0;
      first_match_at_next = 16'd0;
      keep_end_next       = 16'd0;
      phase_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen     <= 1'b0;
      first_match_at <= 16'd0;
      keep_end       <= 16'd0;
      phase          <= 1'b0;
    end else if (load) begin
      match_seen     <= match_seen_next;
      first_match_at <= first_match_at_next;
      keep_end       <= keep_end_next;
      phase          <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  `USDMT_ASSERT_IMP(a_phase_head, phase, q_valid && head.has_char && head.last, "summary phase without last entry")
  `USDMT_ASSERT_NXT(a_sum_clears, issue_sum, !match_seen && (keep_end == 16'd0), "match state not cleared after summary")

endmodule

// File: src/utf8_scan_decode_match_trim.sv
// ---------------------------------------------------------------------------
// utf8_scan_decode_match_trim
// Top level: UTF-8 byte scanner, 16-bit decoder, set matcher and trimmer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one string byte per
//   transfer; last_byte marks the final byte of a string. Output channel
//   (out_valid/out_stall/out_data) carries one result per transfer: a
//   character result for each decoded character, and on the last byte a
//   summary result (found, match_offset, trim_end, valid_bytes, error).
//   The APB port holds set_count, match_char_0..3 and max_len at 4*index;
//   write it only while the block is idle.
//   Throughput: one byte per cycle while the queue is not full. A last byte
//   that also completes a character gives two results from one queue entry.
//   A result is written first to the queue and then loaded into the output
//   register after its byte is taken; an output stall holds it there longer.
//   A 4-entry queue parts the decoder from the matcher; in_stall rises only
//   when that queue is full, so a stalled receiver backs up into it first.
//   Reset (synchronous rst) clears scan state and the queue and sets the
//   registers to set_count 0, match chars 0, max_len 65535.
// ---------------------------------------------------------------------------
module utf8_scan_decode_match_trim (
  input  logic             clk,
  input  logic             rst,
  // byte input
  input  logic             in_valid,
  input  usdmt_pkg::in_t   in_data,
  output logic             in_stall,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output usdmt_pkg::out_t  out_data,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  usdmt_pkg::cfg_t   cfg;
  usdmt_pkg::reg_idx_t reg_sel;
  logic              cfg_wr;

  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic              q_full;
  usdmt_pkg::entry_t q_in;
  usdmt_pkg::entry_t q_head;

  // ---- register file ----
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = usdmt_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_count  <= 3'd0;
      cfg.match_char <= '0;
      cfg.max_len    <= 16'hffff;
    end else if (cfg_wr) begin
      case (reg_sel)
        usdmt_pkg::REG_SET_COUNT: cfg.set_count     <= pwdata[2:0];
        usdmt_pkg::REG_MATCH_0:   cfg.match_char[0] <= pwdata[15:0];
        usdmt_pkg::REG_MATCH_1:   cfg.match_char[1] <= pwdata[15:0];
        usdmt_pkg::REG_MATCH_2:   cfg.match_char[2] <= pwdata[15:0];
        usdmt_pkg::REG_MATCH_3:   cfg.match_char[3] <= pwdata[15:0];
        usdmt_pkg::REG_MAX_LEN:   cfg.max_len       <= pwdata[15:0];
        default:                  cfg.max_len       <= cfg.max_len; // unmapped
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      usdmt_pkg::REG_SET_COUNT: prdata = {29'd0, cfg.set_count};
      usdmt_pkg::REG_MATCH_0:   prdata = {16'd0, cfg.match_char[0]};
      usdmt_pkg::REG_MATCH_1:   prdata = {16'd0, cfg.match_char[1]};
      usdmt_pkg::REG_MATCH_2:   prdata = {16'd0, cfg.match_char[2]};
      usdmt_pkg::REG_MATCH_3:   prdata = {16'd0, cfg.match_char[3]};
      usdmt_pkg::REG_MAX_LEN:   prdata = {16'd0, cfg.max_len};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---- front: decode bytes, track offsets and stop/error ----
  usdmt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .max_len  (cfg.max_len),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // ---- queue: lets decoder run while results wait ----
  usdmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .q_valid    (q_valid),
    .q_full     (q_full)
  );

  // ---- back: match, first-match / trim tracking, output register ----
  usdmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
